>>> src/tpc_pkg.sv
// ----------------------------------------------------------------------------
// tpc_pkg
// Types and constants shared by the touch press classifier files.
// ----------------------------------------------------------------------------
`default_nettype none

package tpc_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned TimeW   = 32;

  localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MEDIUM   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_FOCUS    = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_LONG     = 2'd3;

  localparam logic [CfgW-1:0] DEBOUNCE_RESET = 16'd50;
  localparam logic [CfgW-1:0] MEDIUM_RESET   = 16'd3000;
  localparam logic [CfgW-1:0] FOCUS_RESET    = 16'd7000;
  localparam logic [CfgW-1:0] LONG_RESET     = 16'd8000;

  typedef struct packed {
    logic [CfgW-1:0] lockout_len;
    logic [CfgW-1:0] medium_thr;
    logic [CfgW-1:0] focus_thr;
    logic [CfgW-1:0] long_thr;
  } tpc_cfg_t;

  typedef struct packed {
    logic tapped;
    logic short_released;
    logic medium_released;
    logic focus_pressed;
    logic long_pressed;
  } tpc_events_t;

endpackage

`default_nettype wire

>>> src/tpc_if.sv
// ----------------------------------------------------------------------------
// tpc_if
// Valid/ready channels for touch samples and classified event words.
// ----------------------------------------------------------------------------
`default_nettype none

interface tpc_in_if;
  logic        valid;
  logic        ready;
  logic        touch_level;
  logic [31:0] now_ms;

  modport source (output valid, output touch_level, output now_ms, input ready);
  modport sink   (input valid, input touch_level, input now_ms, output ready);
endinterface

interface tpc_out_if;
  logic valid;
  logic ready;
  logic tapped;
  logic short_released;
  logic medium_released;
  logic focus_pressed;
  logic long_pressed;

  modport source (output valid, output tapped, output short_released,
                  output medium_released, output focus_pressed,
                  output long_pressed, input ready);
  modport sink   (input valid, input tapped, input short_released,
                  input medium_released, input focus_pressed,
                  input long_pressed, output ready);
endinterface

`default_nettype wire

>>> src/tpc_core.sv
// ----------------------------------------------------------------------------
// tpc_core
// Debounce and press duration state; produces the event word of one sample.
// ----------------------------------------------------------------------------
`default_nettype none

module tpc_core
  import tpc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step,
  input  wire logic             touch_level,
  input  wire logic [TimeW-1:0] now_ms,
  input  wire tpc_cfg_t         cfg,
  output tpc_events_t           events
);

  logic             level_r, level_nxt;
  logic [TimeW-1:0] last_r, last_nxt;
  logic             touching_r, touching_nxt;
  logic [TimeW-1:0] start_r, start_nxt;
  logic             focus_r, focus_nxt;
  logic             long_r, long_nxt;

  logic             change;
  logic             press;
  logic             release_ev;
  logic [TimeW-1:0] since_change;
  logic [TimeW-1:0] held_raw;
  logic [TimeW-1:0] held;
  logic             focus_base;
  logic             long_base;

  always_comb begin
    since_change = now_ms - last_r;
    held_raw     = now_ms - start_r;
    change       = (touch_level != level_r) &&
                   (since_change > {{(TimeW-CfgW){1'b0}}, cfg.lockout_len});
    press        = change && touch_level;
    release_ev   = change && !touch_level;
    held         = press ? '0 : held_raw;
    focus_base   = press ? 1'b0 : focus_r;
    long_base    = press ? 1'b0 : long_r;

    level_nxt    = change ? touch_level : level_r;
    last_nxt     = change ? now_ms : last_r;
    touching_nxt = change ? touch_level : touching_r;
    start_nxt    = press ? now_ms : start_r;

    events.tapped          = press;
    events.short_released  = release_ev && !focus_r && !long_r &&
                             (held_raw < {{(TimeW-CfgW){1'b0}}, cfg.medium_thr});
    events.medium_released = release_ev && !focus_r && !long_r &&
                             !(held_raw < {{(TimeW-CfgW){1'b0}}, cfg.medium_thr});
    events.focus_pressed   = touching_nxt && !focus_base &&
                             (held >= {{(TimeW-CfgW){1'b0}}, cfg.focus_thr});
    events.long_pressed    = touching_nxt && !long_base &&
                             (held >= {{(TimeW-CfgW){1'b0}}, cfg.long_thr});

    focus_nxt    = focus_base | events.focus_pressed;
    long_nxt     = long_base | events.long_pressed;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r    <= 1'b0;
      last_r     <= '0;
      touching_r <= 1'b0;
      start_r    <= '0;
      focus_r    <= 1'b0;
      long_r     <= 1'b0;
    end else if (step) begin
      level_r    <= level_nxt;
      last_r     <= last_nxt;
      touching_r <= touching_nxt;
      start_r    <= start_nxt;
      focus_r    <= focus_nxt;
      long_r     <= long_nxt;
    end
  end

endmodule

`default_nettype wire

>>> src/touch_press_classifier.sv
// ----------------------------------------------------------------------------
// touch_press_classifier
// Debounced touch press classifier: one event word per timestamped sample.
// ----------------------------------------------------------------------------
// in_s carries one sample word (raw touch level, 32-bit ms timestamp) and
// out_s returns exactly one event word per sample, in order: tapped,
// short_released, medium_released, focus_pressed, long_pressed.
// A sample is captured into an input register, classified there against the
// press state, and the event word lands in an output register that drives
// out_s.valid; one sample can be taken every cycle while out_s.ready is high
// or the output register is empty. When the receiver stalls, the event word
// holds in the output register and the input register still takes one more
// sample; in_s.ready then drops until out_s.ready returns. cfg_we writes
// cfg_wdata to register cfg_index (0 debounce, 1 medium hold, 2 focus hold,
// 3 long hold); the user must write only while idle, the block does not
// enforce it. Synchronous reset clears both pipeline stages and the press
// state and restores the default thresholds (50, 3000, 7000, 8000 ms).
// ----------------------------------------------------------------------------
`default_nettype none

module touch_press_classifier
  import tpc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  tpc_in_if.sink                  in_s,
  tpc_out_if.source               out_s,
  input  wire logic               cfg_we,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [CfgW-1:0]    cfg_wdata
);

  tpc_cfg_t         cfg_r;
  logic             s1_valid_r;
  logic             s1_level_r;
  logic [TimeW-1:0] s1_now_r;
  logic             out_valid_r;
  tpc_events_t      out_ev_r;
  tpc_events_t      events;
  logic             advance;
  logic             step;

  assign advance    = !out_valid_r || out_s.ready;
  assign step       = s1_valid_r && advance;
  assign in_s.ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lockout_len <= DEBOUNCE_RESET;
      cfg_r.medium_thr  <= MEDIUM_RESET;
      cfg_r.focus_thr   <= FOCUS_RESET;
      cfg_r.long_thr    <= LONG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEBOUNCE: cfg_r.lockout_len <= cfg_wdata;
        CFG_MEDIUM:   cfg_r.medium_thr  <= cfg_wdata;
        CFG_FOCUS:    cfg_r.focus_thr   <= cfg_wdata;
        CFG_LONG:     cfg_r.long_thr    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_s.ready) begin
      s1_valid_r <= in_s.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_s.ready && in_s.valid) begin
      s1_level_r <= in_s.touch_level;
      s1_now_r   <= in_s.now_ms;
    end
  end

  tpc_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .touch_level (s1_level_r),
    .now_ms      (s1_now_r),
    .cfg         (cfg_r),
    .events      (events)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_ev_r <= events;
    end
  end

  assign out_s.valid           = out_valid_r;
  assign out_s.tapped          = out_ev_r.tapped;
  assign out_s.short_released  = out_ev_r.short_released;
  assign out_s.medium_released = out_ev_r.medium_released;
  assign out_s.focus_pressed   = out_ev_r.focus_pressed;
  assign out_s.long_pressed    = out_ev_r.long_pressed;

endmodule

`default_nettype wire

>>> src/tpc_checker.sv
// ----------------------------------------------------------------------------
// tpc_checker
// Port-level checks of the touch press classifier, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tpc_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic tapped,
  input wire logic short_released,
  input wire logic medium_released,
  input wire logic focus_pressed,
  input wire logic long_pressed
);

  // press and release of one word are exclusive
  a_edge_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0({tapped, short_released, medium_released}))
    else $error("press and release in one word");

  // a release is never reported together with a hold event
  a_release_no_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (short_released || medium_released)) |->
      (!focus_pressed && !long_pressed))
    else $error("release reported with hold event");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable({tapped, short_released, medium_released,
                             focus_pressed, long_pressed})))
    else $error("stalled word changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("word valid right after reset");

endmodule

bind touch_press_classifier tpc_checker u_tpc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_s.valid),
  .out_ready       (out_s.ready),
  .tapped          (out_s.tapped),
  .short_released  (out_s.short_released),
  .medium_released (out_s.medium_released),
  .focus_pressed   (out_s.focus_pressed),
  .long_pressed    (out_s.long_pressed)
);

`default_nettype wire
